/* hdl/kvt_pkg.sv */
package kvt_pkg;

  // Default sizes of the table.
  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_VALUE_BITS = 32;

  // Fixed widths of the transfer fields.
  localparam int KIND_W   = 2;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET    = 2'd0,
    KIND_GET    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kvt_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_MISSING = 2'd1,
    STATUS_FULL    = 2'd2
  } kvt_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_REPLY
  } kvt_state_t;

endpackage

/* hdl/kvt_req_if.sv */
interface kvt_req_if import kvt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;

  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);
endinterface

/* hdl/kvt_rsp_if.sv */
interface kvt_rsp_if import kvt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                found;
  logic [VALUE_W-1:0]  read_value;
  logic [STATUS_W-1:0] status;
  logic [TOTAL_W-1:0]  entry_total;

  modport source (output valid, found, read_value, status, entry_total, input ready);
  modport sink   (input valid, found, read_value, status, entry_total, output ready);
endinterface

/* hdl/key_value_table.sv */
// A clear goes from idle straight to the reply state; any other operation first searches the
// live entries, and a remove then shifts the entries above its hit down by one place.
// Only one operation is taken at a time, a limit set by the key memory's single read port,
// which the search and then the shift walk one entry a cycle.
// Reset (synchronous, active high) empties the table and drops any waiting result; the
// memories are not cleared, as only places below the entry count are ever read.
module key_value_table import kvt_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic     clk,
  input  logic     rst,
  kvt_req_if.sink  req,
  kvt_rsp_if.source rsp
);

  localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  // Sequencer state and the operation being worked on.
  kvt_state_t            state, state_next;
  kvt_kind_t             op_kind;
  logic [KEY_BITS-1:0]   op_key;
  logic [VALUE_BITS-1:0] op_value;

  // The number of packed entries; places 0 .. count-1 hold live pairs.
  logic [CNT_W-1:0] count, count_next;

  // Walk pointers. scan_idx is the next place to be read; cmp_idx is the place whose data
  // sits on the memory outputs this cycle, and cmp_vld says that such data is there.
  logic [CNT_W-1:0] scan_idx, scan_idx_next;
  logic [CNT_W-1:0] cmp_idx, cmp_idx_next;
  logic             cmp_vld, cmp_vld_next;
  logic [CNT_W-1:0] shift_dst;

  // Result being built, then the output register that parts the two sides.
  logic               res_found, res_found_next;
  logic [VALUE_W-1:0] res_rval, res_rval_next;
  kvt_status_t        res_status, res_status_next;

  logic                rsp_valid;
  logic                rsp_found;
  logic [VALUE_W-1:0]  rsp_rval;
  logic [STATUS_W-1:0] rsp_status;
  logic [TOTAL_W-1:0]  rsp_total;
  logic                rsp_load;

  // Memory ports, shared by both stores apart from the write enables and data.
  logic                  key_we, val_we;
  logic [ADDR_W-1:0]     waddr, raddr;
  logic [KEY_BITS-1:0]   key_wdata, key_rdata;
  logic [VALUE_BITS-1:0] val_wdata, val_rdata;

  logic req_fire;
  logic hit;
  logic more;

  kvt_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  kvt_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (waddr),
    .wdata (val_wdata),
    .raddr (raddr),
    .rdata (val_rdata)
  );

  // A new operation is taken whenever the sequencer is idle, even while the previous result
  // still waits in the output register.
  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;

  // A hit compares the entry read in the previous cycle; more tells whether live places are
  // still left to be read.
  assign hit       = cmp_vld && (key_rdata == op_key);
  assign more      = (scan_idx < count);
  assign shift_dst = cmp_idx - 1'b1;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          state_next = (kvt_kind_t'(req.kind) == KIND_CLEAR) ? ST_REPLY : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          state_next = (op_kind == KIND_REMOVE) ? ST_SHIFT : ST_REPLY;
        end else if (!more) begin
          state_next = ST_REPLY;
        end
      end
      ST_SHIFT: begin
        if (!cmp_vld && !more) begin
          state_next = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (!rsp_valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    count_next      = count;
    scan_idx_next   = scan_idx;
    cmp_idx_next    = cmp_idx;
    cmp_vld_next    = cmp_vld;
    res_found_next  = res_found;
    res_rval_next   = res_rval;
    res_status_next = res_status;
    key_we          = 1'b0;
    val_we          = 1'b0;
    waddr           = '0;
    raddr           = scan_idx[ADDR_W-1:0];
    key_wdata       = op_key;
    val_wdata       = op_value;

    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          scan_idx_next   = '0;
          cmp_vld_next    = 1'b0;
          res_found_next  = 1'b0;
          res_rval_next   = '0;
          res_status_next = STATUS_DONE;
          if (kvt_kind_t'(req.kind) == KIND_CLEAR) begin
            count_next = '0;
          end
        end
      end

      ST_SEARCH: begin
        if (hit) begin
          res_found_next = 1'b1;
          unique case (op_kind)
            KIND_SET: begin
              // Present key: overwrite its value in place.
              val_we = 1'b1;
              waddr  = cmp_idx[ADDR_W-1:0];
            end
            KIND_GET: begin
              res_rval_next = VALUE_W'(val_rdata);
            end
            KIND_REMOVE: begin
              // The shift starts with the entry just above the hit.
              scan_idx_next = cmp_idx + 1'b1;
              cmp_vld_next  = 1'b0;
            end
            default: ;
          endcase
        end else if (more) begin
          cmp_idx_next  = scan_idx;
          scan_idx_next = scan_idx + 1'b1;
          cmp_vld_next  = 1'b1;
        end else begin
          // Every live entry has been compared without a match.
          unique case (op_kind)
            KIND_SET: begin
              if (count == CNT_W'(ENTRIES)) begin
                res_status_next = STATUS_FULL;
              end else begin
                key_we     = 1'b1;
                val_we     = 1'b1;
                waddr      = count[ADDR_W-1:0];
                count_next = count + 1'b1;
              end
            end
            KIND_GET, KIND_REMOVE: begin
              res_status_next = STATUS_MISSING;
            end
            default: ;
          endcase
        end
      end

      ST_SHIFT: begin
        // Read place i while the pair read from place i-1 is written to place i-2; the
        // read and the write never touch the same entry.
        if (cmp_vld) begin
          key_we    = 1'b1;
          val_we    = 1'b1;
          waddr     = shift_dst[ADDR_W-1:0];
          key_wdata = key_rdata;
          val_wdata = val_rdata;
        end
        if (more) begin
          cmp_idx_next  = scan_idx;
          scan_idx_next = scan_idx + 1'b1;
          cmp_vld_next  = 1'b1;
        end else begin
          cmp_vld_next = 1'b0;
          if (!cmp_vld) begin
            count_next = count - 1'b1;
          end
        end
      end

      ST_REPLY: ;

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      cmp_vld <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      cmp_vld <= cmp_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      op_kind  <= kvt_kind_t'(req.kind);
      op_key   <= KEY_BITS'(req.key);
      op_value <= VALUE_BITS'(req.value);
    end
    scan_idx   <= scan_idx_next;
    cmp_idx    <= cmp_idx_next;
    res_found  <= res_found_next;
    res_rval   <= res_rval_next;
    res_status <= res_status_next;
  end

  // Output register: loaded from the finished result when it is empty or being emptied.
  assign rsp_load = (state == ST_REPLY) && (!rsp_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_found  <= res_found;
      rsp_rval   <= res_rval;
      rsp_status <= res_status;
      rsp_total  <= TOTAL_W'(count);
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.found       = rsp_found;
  assign rsp.read_value  = rsp_rval;
  assign rsp.status      = rsp_status;
  assign rsp.entry_total = rsp_total;

  // The table never holds more entries than it has places.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("entry count beyond table size");

  // A full report is only ever made against a full table.
  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPLY) && (res_status == STATUS_FULL) |-> count == CNT_W'(ENTRIES))
    else $error("table full reported with free places");

  // A clear empties the table at once.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    req_fire && (kvt_kind_t'(req.kind) == KIND_CLEAR) |=> count == '0)
    else $error("clear left entries behind");

  // A missing key is never reported as found.
  a_missing_not_found: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == STATUS_MISSING) |-> !rsp.found)
    else $error("missing key reported as found");

endmodule

/* hdl/kvt_ram.sv */
module kvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
